@@ rtl/ast_pkg.sv @@
// Package with shared types and constants for the associative set table.
package ast_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FUNC_W      = 2;
    localparam int ITEM_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        SS_DONE      = 3'd0,
        SS_PRESENT   = 3'd1,
        SS_FULL      = 3'd2,
        SS_NOT_FOUND = 3'd3,
        SS_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic  active;
        t_func func;
        logic  hit;
        logic  free_found;
    } t_tok;

endpackage

@@ rtl/ast_cell.sv @@
// One slot of the set table that checks a passing request and hands it to the next slot.
module ast_cell #(
    parameter int VALUE_WIDTH = ast_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ast_pkg::t_tok          i_tok,
    input  logic [VALUE_WIDTH-1:0] i_val,
    input  logic                   i_commit_ins,
    input  logic                   i_clear,
    output ast_pkg::t_tok          o_tok,
    output logic [VALUE_WIDTH-1:0] o_val
);
    import ast_pkg::*;

    logic                   r_valid;
    logic                   n_valid;
    logic                   r_claim;
    logic                   n_claim;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    t_tok                   r_tok;
    t_tok                   n_tok;
    logic [VALUE_WIDTH-1:0] r_val_out;
    logic                   w_match;
    logic                   w_take;

    assign w_match = r_valid && (r_value == i_val);
    assign w_take  = i_tok.active && (i_tok.func == FN_INSERT) && !i_tok.free_found
                     && !r_valid;

    always_comb begin
        n_tok   = i_tok;
        n_claim = r_claim;
        n_value = r_value;
        n_valid = r_valid;
        if (i_tok.active) begin
            n_tok.hit        = i_tok.hit | w_match;
            n_tok.free_found = i_tok.free_found | !r_valid;
            n_claim          = w_take;
        end
        if (w_take) begin
            n_value = i_val;
        end
        if (i_clear) begin
            n_valid = 1'b0;
        end else if (i_commit_ins && r_claim) begin
            n_valid = 1'b1;
        end else if (i_tok.active && (i_tok.func == FN_REMOVE) && w_match) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_claim <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_claim <= n_claim;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_val_out <= i_val;
    end

    assign o_tok = r_tok;
    assign o_val = r_val_out;

endmodule

@@ rtl/associative_set_table_top.sv @@
// Top level of the associative set table: request control, slot chain and result register.
// Requests are taken one at a time: the request walks the slot chain one slot per cycle, is
// then committed and loads the result register, and the next request is taken only back in
// the idle state; a result held by the sink stalls the commit.
// Reset (synchronous, active low) empties the set and clears all control state.
module associative_set_table_top #(
    parameter int CAPACITY    = ast_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ast_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ast_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // item_value[31:0]
    input  logic [ast_pkg::IN_TUSER_W-1:0]  i_s_tuser,  // func[1:0], zeros above
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ast_pkg::OUT_TDATA_W-1:0] o_m_tdata   // status[2:0], present[3],
                                                        // now_empty[4], member_count[9:5]
);
    import ast_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                 r_state;
    t_state                 n_state;
    t_tok                   w_tok [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] w_val [CAPACITY+1];
    t_tok                   r_fin;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   w_accept;
    logic                   w_commit;
    logic                   w_commit_ins;
    logic                   w_clear;
    t_status                w_status;
    logic                   w_present;

    assign w_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        w_tok[0]            = '0;
        w_tok[0].active     = w_accept;
        w_tok[0].func       = t_func'(i_s_tuser[FUNC_W-1:0]);
        w_val[0]            = VALUE_WIDTH'(i_s_tdata[ITEM_W-1:0]);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ast_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (w_tok[g]),
            .i_val        (w_val[g]),
            .i_commit_ins (w_commit_ins),
            .i_clear      (w_clear),
            .o_tok        (w_tok[g+1]),
            .o_val        (w_val[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_tok[CAPACITY].active) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready   = (r_state == ST_IDLE);
        w_commit     = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);
        w_commit_ins = 1'b0;
        w_clear      = 1'b0;
        n_count      = r_count;
        w_status     = SS_DONE;
        w_present    = r_fin.hit;
        unique case (r_fin.func)
            FN_LOOKUP: begin
            end
            FN_INSERT: begin
                if (r_fin.hit) begin
                    w_status = SS_PRESENT;
                end else if (!r_fin.free_found) begin
                    w_status = SS_FULL;
                end else begin
                    w_commit_ins = w_commit;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            FN_REMOVE: begin
                if (r_count == '0) begin
                    w_status  = SS_EMPTY;
                    w_present = 1'b0;
                end else if (r_fin.hit) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    w_status = SS_NOT_FOUND;
                end
            end
            FN_CLEAR: begin
                w_present = 1'b0;
                w_clear   = w_commit;
                n_count   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fin       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_WALK) && w_tok[CAPACITY].active) begin
                r_fin <= w_tok[CAPACITY];
            end
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= OUT_TDATA_W'({COUNT_W'(n_count), (n_count == '0), w_present,
                                        w_status});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_idle_chain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_tok[CAPACITY].active)
        else $error("request reached end of slot chain while idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("member count exceeds capacity");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("new request taken while one is in the chain");

    a_commit_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_commit_ins, w_clear}))
        else $error("insert commit and clear at once");

endmodule

@@ dv/associative_set_table_top_test.sv @@
// Self-checking testbench for the associative set table: directed rows, then random set traffic.
module associative_set_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ast_pkg::*;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE   = 24;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        t_status              status;
        logic                 present;
        logic                 now_empty;
        logic [COUNT_W-1:0]   count;
    } t_result;

    typedef struct {
        t_func            func;
        logic [ITEM_W-1:0] value;
        bit               typed;
        t_result          result;
    } t_row;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // item_value[31:0]
    logic [IN_TUSER_W-1:0]  s_tuser = '0;   // func[1:0], zeros above
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // status[2:0], present[3], now_empty[4],
                                            // member_count[9:5]

    bit                     set_used [SLOTS];
    logic [ITEM_W-1:0]      set_value [SLOTS];
    t_result                awaited_results [$];
    t_row                   directed_rows [$];
    logic [ITEM_W-1:0]      value_pool [POOL_SIZE];
    int                     mismatches = 0;
    int                     cycle_count = 0;
    bit                     calm = 1'b0;

    associative_set_table_top #(
        .CAPACITY    (CAPACITY_DEF),
        .VALUE_WIDTH (VALUE_WIDTH_DEF)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic t_result apply_to_set(input t_func func, input logic [ITEM_W-1:0] value);
        t_result r;
        int hit;
        int free_slot;
        int held;
        hit = -1;
        free_slot = -1;
        held = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (set_used[i] && set_value[i] == value && hit < 0) hit = i;
            if (!set_used[i] && free_slot < 0) free_slot = i;
            if (set_used[i]) held++;
        end
        r.status = SS_DONE;
        r.present = 1'b0;
        case (func)
            FN_LOOKUP: begin
                r.present = (hit >= 0);
            end
            FN_INSERT: begin
                if (hit >= 0) begin
                    r.present = 1'b1;
                    r.status = SS_PRESENT;
                end else if (free_slot >= 0) begin
                    set_used[free_slot] = 1'b1;
                    set_value[free_slot] = value;
                end else begin
                    r.status = SS_FULL;
                end
            end
            FN_REMOVE: begin
                if (held == 0) begin
                    r.status = SS_EMPTY;
                end else if (hit >= 0) begin
                    r.present = 1'b1;
                    set_used[hit] = 1'b0;
                end else begin
                    r.status = SS_NOT_FOUND;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) set_used[i] = 1'b0;
            end
        endcase
        held = 0;
        for (int i = 0; i < SLOTS; i++) if (set_used[i]) held++;
        r.now_empty = (held == 0);
        r.count = held[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_func pick_func(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            0: begin
                if (r < 60) return FN_INSERT;
                if (r < 80) return FN_LOOKUP;
                if (r < 98) return FN_REMOVE;
                return FN_CLEAR;
            end
            1: begin
                if (r < 20) return FN_INSERT;
                if (r < 43) return FN_LOOKUP;
                if (r < 98) return FN_REMOVE;
                return FN_CLEAR;
            end
            default: begin
                if (r < 35) return FN_INSERT;
                if (r < 65) return FN_LOOKUP;
                if (r < 96) return FN_REMOVE;
                return FN_CLEAR;
            end
        endcase
    endfunction

    function automatic t_result make_result(input t_status status, input logic present,
                                            input logic now_empty, input int count);
        t_result r;
        r.status = status;
        r.present = present;
        r.now_empty = now_empty;
        r.count = count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic add_row(input t_func func, input logic [ITEM_W-1:0] value, input bit typed,
                           input t_result result);
        t_row row;
        row.func = func;
        row.value = value;
        row.typed = typed;
        row.result = result;
        directed_rows.push_back(row);
    endtask

    task automatic push_request(input t_func func, input logic [ITEM_W-1:0] value,
                                input bit typed, input t_result typed_result);
        t_result predicted;
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tuser <= {{(IN_TUSER_W-FUNC_W){1'b0}}, func};
        do @(posedge clk); while (!s_tready);
        predicted = apply_to_set(func, value);
        awaited_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic idle_sender(input int gap, input bit drain);
        if (gap > 0 || drain) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (drain && awaited_results.size() != 0) @(posedge clk);
        end
    endtask

    initial begin : sink_pacing
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_result seen;
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            seen.status = t_status'(m_tdata[2:0]);
            seen.present = m_tdata[3];
            seen.now_empty = m_tdata[4];
            seen.count = m_tdata[9:5];
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d present %0b empty %0b count %0d",
                             seen.status, seen.present, seen.now_empty, seen.count);
            end else begin
                want = awaited_results.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected status %0d present %0b empty %0b count %0d",
                                 want.status, want.present, want.now_empty, want.count);
                        $display("          got      status %0d present %0b empty %0b count %0d",
                                 seen.status, seen.present, seen.now_empty, seen.count);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("associative_set_table_top_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_result none;
        t_func func;
        logic [ITEM_W-1:0] value;
        int phase;
        none = '0;

        // The full and clear rows at the end rely on the fill rows before them taking the
        // set to full.
        add_row(FN_REMOVE, 32'h1234_5678, 1'b1, make_result(SS_EMPTY, 1'b0, 1'b1, 0));
        add_row(FN_LOOKUP, 32'h0000_0000, 1'b1, make_result(SS_DONE, 1'b0, 1'b1, 0));
        add_row(FN_INSERT, 32'h0000_0000, 1'b1, make_result(SS_DONE, 1'b0, 1'b0, 1));
        add_row(FN_INSERT, 32'h0000_0000, 1'b1, make_result(SS_PRESENT, 1'b1, 1'b0, 1));
        add_row(FN_INSERT, 32'hFFFF_FFFF, 1'b0, none);
        add_row(FN_LOOKUP, 32'hFFFF_FFFF, 1'b0, none);
        add_row(FN_REMOVE, 32'h5555_5555, 1'b0, none);
        add_row(FN_REMOVE, 32'h0000_0000, 1'b0, none);
        for (int i = 0; i < SLOTS - 1; i++)
            add_row(FN_INSERT, 32'hA5A5_0000 ^ (32'h1 << (i + 1)), 1'b0, none);
        add_row(FN_INSERT, 32'hAAAA_AAAA, 1'b1, make_result(SS_FULL, 1'b0, 1'b0, SLOTS));
        add_row(FN_CLEAR, 32'hFFFF_FFFF, 1'b1, make_result(SS_DONE, 1'b0, 1'b1, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            push_request(directed_rows[i].func, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].result);
            idle_sender(($urandom_range(0, 1) == 0) ? 0 : pick_gap(),
                        i == directed_rows.size() - 1);
        end

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n / 80) % 3;
            calm = ((n / 150) % 4 == 3);
            func = pick_func(phase);
            if ($urandom_range(0, 99) < 85)
                value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                value = $urandom;
            push_request(func, value, 1'b0, none);
            idle_sender((calm || $urandom_range(0, 9) < 6) ? 0 : pick_gap(), n == 400);
        end

        idle_sender(0, 1'b1);
        repeat (4 * (SLOTS + 2)) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("associative_set_table_top_test OK");
        end else begin
            $display("associative_set_table_top_test NOT OK");
        end
        $finish;
    end

endmodule
